// File: src/pspm_pkg.sv
// Shared types, codes and constants of the pixel stretch palette mapper.
package pspm_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int PALETTE_DEPTH  = 256;
   localparam int INDEX_W        = 8;
   localparam int PIXEL_W        = 16;
   localparam int COLOR_W        = 32;
   localparam int OP_W           = 2;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 13;
   localparam int BRIGHT_W       = 10;
   localparam int CONTRAST_W     = 7;
   localparam int SIZE_W         = 13;
   localparam int NUM_W          = 25;
   localparam int DEN_W          = 17;
   localparam int STEP_W         = 4;

   localparam logic [COLOR_W-1:0] RETICLE_MASK = 32'h0000_8000;
   localparam logic [STEP_W-1:0]  DIV_TOP      = 4'd8;
   localparam logic [STEP_W-1:0]  DIV_LAST     = 4'd0;

   localparam logic [OP_W-1:0] OP_PAL_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_SCAN      = 2'd1;
   localparam logic [OP_W-1:0] OP_MAP       = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_AUTO_MODE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTRAST     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETICLE_ON   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_READ,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic              accept;
      logic              prep;
      logic              div_step;
      logic [STEP_W-1:0] div_bit;
      logic              load_out;
   } cmd_type;

   typedef struct packed {
      logic out_full;
   } status_type;

endpackage

// File: src/pspm_req_if.sv
// Input channel: valid/ready handshake with the request payload.
interface pspm_req_if import pspm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [PIXEL_W-1:0] pixel;
   logic               frame_start;
   logic [INDEX_W-1:0] palette_index;
   logic [COLOR_W-1:0] palette_word;

   modport source (output valid, operation, pixel, frame_start, palette_index,
                   palette_word, input ready);
   modport sink (input valid, operation, pixel, frame_start, palette_index,
                 palette_word, output ready);
endinterface

// File: src/pspm_rsp_if.sv
// Result channel: valid/ready handshake with the color payload.
interface pspm_rsp_if import pspm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] color_word;
   logic [INDEX_W-1:0] color_index;

   modport source (output valid, color_word, color_index, input ready);
   modport sink (input valid, color_word, color_index, output ready);
endinterface

// File: src/pspm_ram.sv
// Generic single write port RAM with registered read.
module pspm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: src/pspm_datapath.sv
// Datapath: settings, min/max, raster position, range divider, palette, result register.
module pspm_datapath import pspm_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [OP_W-1:0]        operation,
   input  logic [PIXEL_W-1:0]     pixel,
   input  logic                   frame_start,
   input  logic [INDEX_W-1:0]     palette_index,
   input  logic [COLOR_W-1:0]     palette_word,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COLOR_W-1:0]     color_word,
   output logic [INDEX_W-1:0]     color_index
);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WSZ_W  = $clog2(MAX_WIDTH + 1);
   localparam int HSZ_W  = $clog2(MAX_HEIGHT + 1);

   // settings
   logic                         auto_ff;
   logic signed [BRIGHT_W-1:0]   bright_ff;
   logic [CONTRAST_W-1:0]        contrast_ff;
   logic                         reticle_ff;
   logic [SIZE_W-1:0]            width_ff;
   logic [SIZE_W-1:0]            height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_ff     <= 1'b0;
         bright_ff   <= '0;
         contrast_ff <= CONTRAST_W'(1);
         reticle_ff  <= 1'b0;
         width_ff    <= SIZE_W'(640);
         height_ff   <= SIZE_W'(480);
      end else if (csr_we) begin
         case (csr_index)
            CSR_AUTO_MODE:    auto_ff     <= csr_wdata[0];
            CSR_BRIGHTNESS:   bright_ff   <= $signed(csr_wdata[BRIGHT_W-1:0]);
            CSR_CONTRAST:     contrast_ff <= csr_wdata[CONTRAST_W-1:0];
            CSR_RETICLE_ON:   reticle_ff  <= csr_wdata[0];
            CSR_FRAME_WIDTH:  width_ff    <= csr_wdata[SIZE_W-1:0];
            CSR_FRAME_HEIGHT: height_ff   <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // effective frame size
   logic [WSZ_W-1:0] eff_w;
   logic [HSZ_W-1:0] eff_h;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = WSZ_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = WSZ_W'(MAX_WIDTH);
      end else begin
         eff_w = WSZ_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = HSZ_W'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = HSZ_W'(MAX_HEIGHT);
      end else begin
         eff_h = HSZ_W'(height_ff);
      end
   end

   // raster position and reticle hit, taken at the accepted map beat
   logic [COL_W-1:0] col_ff, col_cur, col_in;
   logic [ROW_W-1:0] row_ff, row_cur, row_in;
   logic [WSZ_W-1:0] col_inc;
   logic [HSZ_W-1:0] row_inc;
   logic             hit_ff, hit_in;
   int               w_half, w_first, w_second, h_half, h_first, h_second;
   logic             col_hit, row_hit;

   always_comb begin
      col_cur  = frame_start ? '0 : col_ff;
      row_cur  = frame_start ? '0 : row_ff;
      w_half   = int'(eff_w >> 1);
      w_first  = w_half - 1 - (eff_w[0] ? 0 : 1);
      w_second = w_half + 1;
      h_half   = int'(eff_h >> 1);
      h_first  = h_half - 1 - (eff_h[0] ? 0 : 1);
      h_second = h_half + 1;
      col_hit  = (w_first >= 0 && w_first < int'(eff_w) && int'(col_cur) == w_first)
               || (w_second < int'(eff_w) && int'(col_cur) == w_second);
      row_hit  = (h_first >= 0 && h_first < int'(eff_h) && int'(row_cur) == h_first)
               || (h_second < int'(eff_h) && int'(row_cur) == h_second);
      hit_in   = reticle_ff && (col_hit || row_hit);
      col_inc  = WSZ_W'(col_cur) + WSZ_W'(1);
      row_inc  = HSZ_W'(row_cur) + HSZ_W'(1);
      col_in   = COL_W'(col_inc);
      row_in   = row_cur;
      if (col_inc >= eff_w) begin
         col_in = '0;
         row_in = (row_inc >= eff_h) ? '0 : ROW_W'(row_inc);
      end
   end

   logic map_acc, scan_acc, pal_acc;
   assign map_acc  = cmd.accept && (operation == OP_MAP);
   assign scan_acc = cmd.accept && (operation == OP_SCAN);
   assign pal_acc  = cmd.accept && (operation == OP_PAL_WRITE);

   logic [PIXEL_W-1:0] min_ff, max_ff, pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         min_ff <= '1;
         max_ff <= '0;
      end else begin
         if (map_acc) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (scan_acc) begin
            if (frame_start) begin
               min_ff <= pixel;
               max_ff <= pixel;
            end else begin
               if (pixel > max_ff) max_ff <= pixel;
               if (pixel < min_ff) min_ff <= pixel;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (map_acc) begin
         pix_ff <= pixel;
         hit_ff <= hit_in;
      end
   end

   // numerator and divisor for the range divider
   logic signed [PIXEL_W+1:0]  m_s, diff_a;
   logic [DEN_W-1:0]           d_a;
   logic [NUM_W-1:0]           num_a;
   logic signed [PIXEL_W+2:0]  diff_m;
   logic signed [PIXEL_W+10:0] prod_m;
   logic                       inv_a;
   logic                       man_sat;
   logic [PIXEL_W:0]           man_sum;

   always_comb begin
      inv_a = max_ff < min_ff;
      if (max_ff == min_ff) begin
         m_s = $signed({2'b00, min_ff}) - 18'sd1;
         d_a = DEN_W'(1);
      end else begin
         m_s = $signed({2'b00, min_ff});
         d_a = DEN_W'(max_ff) - DEN_W'(min_ff);
      end
      diff_a = $signed({2'b00, pix_ff}) - m_s;
      num_a  = (NUM_W'(diff_a[PIXEL_W:0]) << 8) - NUM_W'(diff_a[PIXEL_W:0]);
      diff_m = $signed({3'b000, pix_ff}) - $signed({{1{bright_ff[BRIGHT_W-1]}}, bright_ff, 8'h00});
      prod_m = diff_m * $signed({1'b0, contrast_ff});
      // divide by 255: quotient of 256 or more saturates, else (x + x/256 + 1) / 256
      man_sat = prod_m[NUM_W-1:0] >= NUM_W'(255 * 256);
      man_sum = {1'b0, prod_m[PIXEL_W-1:0]} + (PIXEL_W+1)'(prod_m[PIXEL_W-1:8])
              + (PIXEL_W+1)'(1);
   end

   logic [NUM_W-1:0]   num_ff;
   logic [DEN_W-1:0]   den_ff;
   logic               zero_ff, sat_ff;
   logic [INDEX_W-1:0] q_ff;
   logic [NUM_W-1:0]   den_sh;

   assign den_sh = NUM_W'(den_ff) << cmd.div_bit;

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         if (auto_ff) begin
            q_ff    <= '0;
            sat_ff  <= 1'b0;
            num_ff  <= num_a;
            den_ff  <= d_a;
            zero_ff <= inv_a || diff_a[PIXEL_W+1];
         end else begin
            // manual index is final here; zero numerator keeps the divider idle
            q_ff    <= man_sum[PIXEL_W-1:8];
            sat_ff  <= man_sat;
            num_ff  <= '0;
            den_ff  <= DEN_W'(1);
            zero_ff <= prod_m[PIXEL_W+10];
         end
      end else if (cmd.div_step) begin
         // restoring step: one quotient bit per cycle, top bit means saturation
         if (num_ff >= den_sh) begin
            num_ff <= num_ff - den_sh;
            if (cmd.div_bit == DIV_TOP) begin
               sat_ff <= 1'b1;
            end else begin
               q_ff[cmd.div_bit[2:0]] <= 1'b1;
            end
         end
      end
   end

   logic [INDEX_W-1:0] idx;
   assign idx = zero_ff ? '0 : (sat_ff ? '1 : q_ff);

   logic [COLOR_W-1:0] pal_data;

   pspm_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_acc),
      .wr_addr (palette_index),
      .wr_data (palette_word),
      .rd_addr (idx),
      .rd_data (pal_data)
   );

   // result register
   logic               out_valid_ff;
   logic [COLOR_W-1:0] color_ff;
   logic [INDEX_W-1:0] index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         color_ff <= pal_data | (hit_ff ? RETICLE_MASK : '0);
         index_ff <= idx;
      end
   end

   assign status.out_full = out_valid_ff && !rsp_ready;
   assign rsp_valid       = out_valid_ff;
   assign color_word      = color_ff;
   assign color_index     = index_ff;
endmodule

// File: src/pspm_ctrl.sv
// Controller: sequences accept, operand prep, divide steps, palette read and result load.
module pspm_ctrl import pspm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] operation,
   output logic            req_ready,
   input  status_type      status,
   output cmd_type         cmd
);
   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && operation == OP_MAP) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_DIV;
            step_in  = DIV_TOP;
         end
         ST_DIV: begin
            if (step_ff == DIV_LAST) begin
               state_in = ST_READ;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: begin
            if (!status.out_full) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.div_bit  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_PREP: cmd.prep     = 1'b1;
         ST_DIV:  cmd.div_step = 1'b1;
         ST_READ: ;
         ST_LOAD: cmd.load_out = !status.out_full;
         default: ;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && step_ff == DIV_LAST) |=> state_ff == ST_READ)
      else $error("divider did not hand over to palette read");
   a_map_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && operation == OP_MAP) |=> state_ff == ST_PREP)
      else $error("map beat did not start the divide");
   a_other_stays: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && operation != OP_MAP) |=> state_ff == ST_IDLE)
      else $error("non-map beat left idle");
   a_load_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && status.out_full) |=> state_ff == ST_LOAD)
      else $error("result load dropped while output was full");
`endif
endmodule

// File: src/pixel_stretch_palette_map.sv
// Top level: maps 16-bit pixels to palette colors by min/max or manual stretch.
// Palette write, scan and unused-code beats are accepted and done at the accepting edge.
// A map beat runs from accept to result valid through operand prep, nine divider
// steps, palette read and result load; a full output register holds the load.
// The next beat is accepted in the cycle after the result is loaded into the output register.
// Sync active-high reset: settings to defaults, min 0xFFFF, max 0, position 0, palette kept.
module pixel_stretch_palette_map import pspm_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   pspm_req_if.sink               req_bus,
   pspm_rsp_if.source             rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);
   cmd_type    cmd;
   status_type status;

   // controller owns the handshake on the request side
   pspm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .operation (req_bus.operation),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath holds all payload state and the result register
   pspm_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .operation     (req_bus.operation),
      .pixel         (req_bus.pixel),
      .frame_start   (req_bus.frame_start),
      .palette_index (req_bus.palette_index),
      .palette_word  (req_bus.palette_word),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .color_word    (rsp_bus.color_word),
      .color_index   (rsp_bus.color_index)
   );
endmodule

// File: tb/sv/pspm_color_checker.sv
// Watches the request, result and register ports; predicts each color and compares.
module pspm_color_checker import pspm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   pspm_req_if                    req,
   pspm_rsp_if                    rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     pending,
   output int                     fail_count,
   output int                     colors_checked
);

   typedef struct packed {
      logic [COLOR_W-1:0] word;
      logic [INDEX_W-1:0] index;
   } color_result_type;

   color_result_type            expected_colors[$];
   logic [COLOR_W-1:0]          palette[PALETTE_DEPTH];
   logic                        auto_mode;
   logic signed [BRIGHT_W-1:0]  brightness;
   logic [CONTRAST_W-1:0]       contrast;
   logic                        reticle_on;
   logic [SIZE_W-1:0]           frame_width;
   logic [SIZE_W-1:0]           frame_height;
   logic [PIXEL_W-1:0]          min_seen;
   logic [PIXEL_W-1:0]          max_seen;
   int                          column_pos;
   int                          row_pos;

   initial begin
      fail_count     = 0;
      colors_checked = 0;
      pending        = 0;
      foreach (palette[i]) palette[i] = '0;
   end

   task automatic report(string what, longint exp_val, longint got_val);
      $display("MISMATCH %s: expected %0h got %0h (result %0d)", what, exp_val, got_val,
               colors_checked);
      fail_count++;
   endtask

   function automatic int clip_size(logic [SIZE_W-1:0] v, int maxv);
      if (v == 0) return 1;
      if (int'(v) > maxv) return maxv;
      return int'(v);
   endfunction

   // two lines straddle the center; a line off the frame never matches
   function automatic bit on_center_line(int pos, int size);
      int half;
      int first;
      half  = size / 2;
      first = half - 1 - ((size & 1) ^ 1);
      if (first >= 0 && first < size && pos == first) return 1'b1;
      if (half + 1 < size && pos == half + 1) return 1'b1;
      return 1'b0;
   endfunction

   function automatic color_result_type predict_color(logic [PIXEL_W-1:0] pixel, logic start);
      color_result_type res;
      longint        idx;
      longint        lo;
      longint        span;
      longint        num;
      int            w;
      int            h;
      w = clip_size(frame_width, DEF_MAX_WIDTH);
      h = clip_size(frame_height, DEF_MAX_HEIGHT);
      if (start) begin
         column_pos = 0;
         row_pos    = 0;
      end
      if (auto_mode) begin
         lo   = longint'(min_seen);
         span = longint'(max_seen) - lo;
         if (span < 0) begin
            idx = 0;   // nothing scanned yet
         end else begin
            if (span == 0) begin
               lo   = lo - 1;
               span = 1;
            end
            num = (longint'(pixel) - lo) * 255;
            idx = (num < 0) ? 0 : num / span;
         end
      end else begin
         num = (longint'(pixel) - longint'(brightness) * 256) * longint'(contrast);
         idx = (num < 0) ? 0 : num / 255;
      end
      if (idx > 255) idx = 255;
      res.index = idx[INDEX_W-1:0];
      res.word  = palette[res.index];
      if (reticle_on && (on_center_line(column_pos, w) || on_center_line(row_pos, h)))
         res.word = res.word | RETICLE_MASK;
      column_pos++;
      if (column_pos >= w) begin
         column_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      color_result_type exp_res;
      if (reset) begin
         auto_mode    = 1'b0;
         brightness   = '0;
         contrast     = 7'd1;
         reticle_on   = 1'b0;
         frame_width  = 13'd640;
         frame_height = 13'd480;
         min_seen     = 16'hFFFF;
         max_seen     = '0;
         column_pos   = 0;
         row_pos      = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_AUTO_MODE:    auto_mode    = csr_wdata[0];
               CSR_BRIGHTNESS:   brightness   = csr_wdata[BRIGHT_W-1:0];
               CSR_CONTRAST:     contrast     = csr_wdata[CONTRAST_W-1:0];
               CSR_RETICLE_ON:   reticle_on   = csr_wdata[0];
               CSR_FRAME_WIDTH:  frame_width  = csr_wdata[SIZE_W-1:0];
               CSR_FRAME_HEIGHT: frame_height = csr_wdata[SIZE_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            case (req.operation)
               OP_PAL_WRITE: palette[req.palette_index] = req.palette_word;
               OP_SCAN: begin
                  if (req.frame_start) begin
                     min_seen = req.pixel;
                     max_seen = req.pixel;
                  end else begin
                     if (req.pixel > max_seen) max_seen = req.pixel;
                     if (req.pixel < min_seen) min_seen = req.pixel;
                  end
               end
               OP_MAP: expected_colors.push_back(predict_color(req.pixel, req.frame_start));
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_colors.size() == 0) begin
               report("unexpected beat", 0, rsp.color_word);
            end else begin
               exp_res = expected_colors.pop_front();
               if (rsp.color_word !== exp_res.word)
                  report("color_word", exp_res.word, rsp.color_word);
               if (rsp.color_index !== exp_res.index)
                  report("color_index", exp_res.index, rsp.color_index);
            end
            colors_checked++;
         end
      end
      pending <= expected_colors.size();
   end

endmodule

// File: tb/sv/tb_top.sv
// Stimulus and verdict for the pixel stretch palette mapper.
module tb_top;
   import pspm_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int ITEMS_PER_PHASE = 40;
   localparam int NUM_PHASES      = 8;
   localparam int SETTLE_CYCLES   = 20;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     pending;
   int                     fail_count;
   int                     colors_checked;
   int                     cycles = 0;
   int                     send_idle = 0;   // percent of cycles the sender holds back
   int                     rcv_idle = 0;    // percent of cycles the receiver stalls
   int                     beats_sent = 0;

   pspm_req_if req_bus();
   pspm_rsp_if rsp_bus();

   pixel_stretch_palette_map u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pspm_color_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req_bus),
      .rsp            (rsp_bus),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .pending        (pending),
      .fail_count     (fail_count),
      .colors_checked (colors_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver stalls at random, rate set per phase
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rcv_idle);
   end

   // one request beat; valid stays high across back-to-back beats
   task automatic send_beat(logic [OP_W-1:0] op, logic [PIXEL_W-1:0] pixel, logic start,
                            logic [INDEX_W-1:0] pal_index, logic [COLOR_W-1:0] pal_word);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.operation     <= op;
      req_bus.pixel         <= pixel;
      req_bus.frame_start   <= start;
      req_bus.palette_index <= pal_index;
      req_bus.palette_word  <= pal_word;
      do @(posedge clock); while (!req_bus.ready);
      if (op != OP_UNUSED) beats_sent++;
   endtask

   // hold off until every predicted color has come back, then let the pipe settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_registers(logic automode, int bright, int contr, logic reticle,
                                int width, int height);
      logic [CSR_DATA_W-1:0] vals[6];
      vals[CSR_AUTO_MODE]    = automode;
      vals[CSR_BRIGHTNESS]   = bright[BRIGHT_W-1:0];
      vals[CSR_CONTRAST]     = contr[CONTRAST_W-1:0];
      vals[CSR_RETICLE_ON]   = reticle;
      vals[CSR_FRAME_WIDTH]  = width[SIZE_W-1:0];
      vals[CSR_FRAME_HEIGHT] = height[SIZE_W-1:0];
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= i[CSR_INDEX_W-1:0];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [PIXEL_W-1:0] pick_pixel();
      case ($urandom_range(5))
         0: return '0;
         1: return 16'hFFFF;
         2: return PIXEL_W'($urandom_range(300));
         default: return PIXEL_W'($urandom);
      endcase
   endfunction

   // mostly maps; some scan bursts that open a frame, palette writes, noise and op 3
   task automatic send_random_beat();
      int                 sel;
      int                 len;
      logic [PIXEL_W-1:0] base;
      sel = $urandom_range(99);
      if (sel < 8) begin
         send_beat(OP_PAL_WRITE, PIXEL_W'($urandom), 1'($urandom), INDEX_W'($urandom),
                   COLOR_W'($urandom));
      end else if (sel < 18) begin
         len  = $urandom_range(3, 8);
         base = pick_pixel();
         for (int i = 0; i < len; i++)
            send_beat(OP_SCAN, base ^ PIXEL_W'($urandom_range(16'h0FFF)), i == 0,
                      INDEX_W'($urandom), COLOR_W'($urandom));
      end else if (sel < 21) begin
         send_beat(OP_SCAN, pick_pixel(), 1'($urandom), INDEX_W'($urandom),
                   COLOR_W'($urandom));
      end else if (sel < 25) begin
         send_beat(OP_UNUSED, PIXEL_W'($urandom), 1'($urandom), INDEX_W'($urandom),
                   COLOR_W'($urandom));
      end else begin
         send_beat(OP_MAP, pick_pixel(), $urandom_range(15) == 0, INDEX_W'($urandom),
                   COLOR_W'($urandom));
      end
   endtask

   initial begin
      int phase_start;
      req_bus.valid         <= 1'b0;
      req_bus.operation     <= OP_PAL_WRITE;
      req_bus.pixel         <= '0;
      req_bus.frame_start   <= 1'b0;
      req_bus.palette_index <= '0;
      req_bus.palette_word  <= '0;
      csr_we                <= 1'b0;
      csr_index             <= '0;
      csr_wdata             <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // auto stretch first so the empty-range case is seen before any scan
      set_registers(1'b1, 0, 1, 1'b1, 640, 480);

      // every palette entry gets a color before any map can read it
      for (int i = 0; i < PALETTE_DEPTH; i++)
         send_beat(OP_PAL_WRITE, PIXEL_W'($urandom), 1'b0, i[INDEX_W-1:0],
                   COLOR_W'($urandom));

      // directed: empty range, flat range, below and above range, op 3, palette extremes
      send_beat(OP_MAP, 16'd500, 1'b1, '0, '0);
      send_beat(OP_UNUSED, 16'd123, 1'b1, 8'hFF, 32'hFFFF_FFFF);
      send_beat(OP_SCAN, 16'd1000, 1'b1, '0, '0);
      send_beat(OP_MAP, 16'd1000, 1'b0, '0, '0);
      send_beat(OP_MAP, 16'd999, 1'b0, '0, '0);
      send_beat(OP_MAP, 16'd0, 1'b0, '0, '0);
      send_beat(OP_MAP, 16'hFFFF, 1'b0, '0, '0);
      send_beat(OP_SCAN, 16'd0, 1'b0, '0, '0);
      send_beat(OP_SCAN, 16'hFFFF, 1'b0, '0, '0);
      send_beat(OP_MAP, 16'h8000, 1'b0, '0, '0);
      send_beat(OP_PAL_WRITE, '0, 1'b0, 8'hFF, 32'hFFFF_FFFF);
      send_beat(OP_PAL_WRITE, '0, 1'b1, 8'h00, 32'h0000_0000);
      send_beat(OP_MAP, 16'hFFFF, 1'b1, '0, '0);
      send_beat(OP_MAP, 16'h0000, 1'b0, '0, '0);
      send_beat(OP_SCAN, 16'd100, 1'b1, '0, '0);
      send_beat(OP_SCAN, 16'd355, 1'b0, '0, '0);
      send_beat(OP_MAP, 16'd200, 1'b0, '0, '0);
      send_beat(OP_MAP, 16'd355, 1'b0, '0, '0);
      send_beat(OP_MAP, 16'd99, 1'b0, '0, '0);
      drain();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         // receiver-heavy idling, then sender-heavy, then none
         if (phase < 3) begin
            send_idle = 25;
            rcv_idle  = 63;
         end else if (phase < 6) begin
            send_idle = 63;
            rcv_idle  = 25;
         end else begin
            send_idle = 0;
            rcv_idle  = 0;
         end
         case (phase)
            0: set_registers(1'b0, 0, 1, 1'b1, 5, 4);
            1: set_registers(1'b0, -32, 96, 1'b1, 4, 3);
            2: set_registers(1'b0, -512, 127, 1'b1, 1, 1);
            3: set_registers(1'b0, 511, 0, 1'b1, 8191, 8191);
            4: set_registers(1'b1, 256, 50, 1'b1, 3, 6);
            5: set_registers(1'b1, 0, 1, 1'b1, 0, 0);
            6: set_registers(1'b0, $urandom_range(8) - 4, $urandom_range(1, 3), 1'b1, 7, 2);
            default: set_registers(1'b1, -1, 127, 1'b1, 4096, 2);
         endcase
         phase_start = beats_sent;
         while (beats_sent - phase_start < ITEMS_PER_PHASE) begin
            send_random_beat();
            // one mid-phase pause until the result side is empty
            if (phase == 1 && beats_sent - phase_start == ITEMS_PER_PHASE / 2) drain();
         end
         drain();
      end

      $display("Sent %0d request beats and checked %0d colors over %0d register settings,",
               beats_sent, colors_checked, NUM_PHASES + 1);
      $display("under sender-heavy, receiver-heavy and no idling.");
      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d colors never arrived", fail_count, pending);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
